// ===== rtl/ssp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

    // longest parameter value that is gathered
    localparam int MAX_VALUE_BYTES = 8;
    localparam int VALUE_LEFT_W    = $clog2(MAX_VALUE_BYTES + 1);
    localparam int SHIFT_W         = 3;
    localparam int ACCUM_W         = 64;

    // parameter type codes
    localparam logic [7:0] PT_ACCEPT_ITEM = 8'h05;
    localparam logic [7:0] PT_SESSION_REQ = 8'h14;
    localparam logic [7:0] PT_CALLING_SEL = 8'h33;
    localparam logic [7:0] PT_CALLED_SEL  = 8'h34;
    localparam logic [7:0] PT_USER_DATA   = 8'hC1;

    // sub-item type codes inside a connect accept item
    localparam logic [7:0] SI_OPTIONS     = 8'h13;
    localparam logic [7:0] SI_VERSION     = 8'h16;

    // register indexes
    localparam logic [2:0] REG_OPTIONS     = 3'd0;
    localparam logic [2:0] REG_VERSION     = 3'd1;
    localparam logic [2:0] REG_SESSION_REQ = 3'd2;
    localparam logic [2:0] REG_CALLING_SEL = 3'd3;
    localparam logic [2:0] REG_CALLED_SEL  = 3'd4;

    // verdict and end codes
    typedef enum logic [3:0] {
        ST_USER_DATA    = 4'd0,
        ST_OPTIONS      = 4'd1,
        ST_VERSION      = 4'd2,
        ST_UNKNOWN_SUB  = 4'd3,
        ST_REQUIREMENT  = 4'd4,
        ST_CALLING      = 4'd5,
        ST_CALLED       = 4'd6,
        ST_UNKNOWN_TYPE = 4'd7,
        ST_CLEAN_END    = 4'd8,
        ST_TRUNCATED    = 4'd9,
        ST_TOO_LONG     = 4'd10
    } ssp_status_t;

    // expected values held in the register bank
    typedef struct packed {
        logic [7:0]  options;
        logic [7:0]  version;
        logic [15:0] session_req;
        logic [15:0] calling_sel;
        logic [15:0] called_sel;
    } ssp_cfg_t;

    // one result word
    typedef struct packed {
        ssp_status_t status;
        logic [7:0]  user_data_length;
    } ssp_result_t;

endpackage

`default_nettype wire

// ===== rtl/session_spdu_param_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Session SPDU parameter checker.
// Input channel (in_valid / in_ready, data_byte, last) takes one byte of the
// SPDU parameter area per word; last marks the final byte of a stream.
// Output channel (out_valid / out_ready, status, user_data_length) gives at
// most one word per input byte: a verdict, or the clean / truncated end code
// on the last byte. user_data_length is valid with status 0 and is 0 else.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
// expected values; it is always ready and an unknown index is dropped.
// Throughput: one byte per cycle while the result buffer has space; the parser
// update between the input register and the two-entry result buffer is combinational.
// A result is pushed into the result buffer as its byte leaves the input register,
// and is shown on the output from that buffer.
// Reset clears the parser and the result buffer and loads the default
// expected values. When the receiver stalls, the result buffer holds up to
// two words; once it is full the input register holds its byte and
// in_ready drops until a word is taken.

module session_spdu_param_checker
    import ssp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       status,
    output logic [7:0]       user_data_length,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    ssp_cfg_t     cfg_reg;
    logic         stage_valid_reg, stage_valid_next;
    logic [7:0]   stage_byte_reg;
    logic         stage_last_reg;
    logic         in_fire;
    logic         fire;
    logic         space;
    logic         res_valid;
    ssp_result_t  res;
    ssp_result_t  out_word;

    assign cfg_ready = 1'b1;

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.options     <= 8'h00;
            cfg_reg.version     <= 8'h02;
            cfg_reg.session_req <= 16'h0200;
            cfg_reg.calling_sel <= 16'h0100;
            cfg_reg.called_sel  <= 16'h0100;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OPTIONS:     cfg_reg.options     <= cfg_data[7:0];
                REG_VERSION:     cfg_reg.version     <= cfg_data[7:0];
                REG_SESSION_REQ: cfg_reg.session_req <= cfg_data;
                REG_CALLING_SEL: cfg_reg.calling_sel <= cfg_data;
                REG_CALLED_SEL:  cfg_reg.called_sel  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // input register
    assign fire     = stage_valid_reg & space;
    assign in_ready = ~stage_valid_reg | space;
    assign in_fire  = in_valid & in_ready;

    always_comb
    begin
        stage_valid_next = in_fire | (stage_valid_reg & ~fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_byte_reg <= data_byte;
            stage_last_reg <= last;
        end
    end

    ssp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (stage_byte_reg),
        .last      (stage_last_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ssp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_word)
    );

    assign status           = out_word.status;
    assign user_data_length = out_word.user_data_length;

endmodule

`default_nettype wire

// ===== rtl/ssp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssp_parser
    import ssp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last,
    input  wire ssp_cfg_t    cfg,
    output logic             res_valid,
    output ssp_result_t      res
);

    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2,
        PH_ITEM  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        SUB_TYPE  = 2'd0,
        SUB_LEN   = 2'd1,
        SUB_VALUE = 2'd2
    } sub_phase_t;

    phase_t                  phase_reg, phase_next;
    logic [7:0]              kind_reg, kind_next;
    logic [7:0]              item_left_reg, item_left_next;
    sub_phase_t              sub_reg, sub_next;
    logic [7:0]              sub_kind_reg, sub_kind_next;
    logic [VALUE_LEFT_W-1:0] value_left_reg, value_left_next;
    logic [ACCUM_W-1:0]      accum_reg, accum_next;
    logic [SHIFT_W-1:0]      shift_reg, shift_next;
    logic                    verdict_reg, verdict_next;

    logic                    v_valid;
    ssp_status_t             v_code;
    logic [7:0]              v_udl;
    logic [ACCUM_W-1:0]      cmp_accum;
    logic [15:0]             want;
    ssp_status_t             mismatch_code;
    logic [ACCUM_W-1:0]      byte_shifted;

    // expected value and code for the current parameter kind
    always_comb
    begin
        if (kind_reg == PT_SESSION_REQ)
        begin
            want          = cfg.session_req;
            mismatch_code = ST_REQUIREMENT;
        end
        else if (kind_reg == PT_CALLING_SEL)
        begin
            want          = cfg.calling_sel;
            mismatch_code = ST_CALLING;
        end
        else
        begin
            want          = cfg.called_sel;
            mismatch_code = ST_CALLED;
        end
    end

    // little-endian byte placement
    assign byte_shifted = {{(ACCUM_W-8){1'b0}}, data_byte} << {shift_reg, 3'b000};

    // next state and verdict for one word
    always_comb
    begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        item_left_next  = item_left_reg;
        sub_next        = sub_reg;
        sub_kind_next   = sub_kind_reg;
        value_left_next = value_left_reg;
        accum_next      = accum_reg;
        shift_next      = shift_reg;
        v_valid         = 1'b0;
        v_code          = ST_CLEAN_END;
        v_udl           = 8'd0;
        cmp_accum       = accum_reg;

        if (!verdict_reg)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    kind_next = data_byte;
                    if (data_byte == PT_ACCEPT_ITEM || data_byte == PT_SESSION_REQ ||
                        data_byte == PT_CALLING_SEL || data_byte == PT_CALLED_SEL ||
                        data_byte == PT_USER_DATA)
                    begin
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        v_valid = 1'b1;
                        v_code  = ST_UNKNOWN_TYPE;
                    end
                end
                PH_LEN:
                begin
                    if (kind_reg == PT_USER_DATA)
                    begin
                        v_valid = 1'b1;
                        v_code  = ST_USER_DATA;
                        v_udl   = data_byte;
                    end
                    else if (kind_reg == PT_ACCEPT_ITEM)
                    begin
                        item_left_next = data_byte;
                        sub_next       = SUB_TYPE;
                        phase_next     = (data_byte != 8'd0) ? PH_ITEM : PH_TYPE;
                    end
                    else if (data_byte > 8'(MAX_VALUE_BYTES))
                    begin
                        v_valid = 1'b1;
                        v_code  = ST_TOO_LONG;
                    end
                    else
                    begin
                        accum_next      = '0;
                        shift_next      = '0;
                        value_left_next = data_byte[VALUE_LEFT_W-1:0];
                        if (data_byte == 8'd0)
                        begin
                            // empty value counts as zero
                            cmp_accum  = '0;
                            phase_next = PH_TYPE;
                            if (cmp_accum != {{(ACCUM_W-16){1'b0}}, want})
                            begin
                                v_valid = 1'b1;
                                v_code  = mismatch_code;
                            end
                        end
                        else
                        begin
                            phase_next = PH_VALUE;
                        end
                    end
                end
                PH_VALUE:
                begin
                    accum_next      = accum_reg | byte_shifted;
                    shift_next      = shift_reg + SHIFT_W'(1);
                    value_left_next = (value_left_reg != '0) ?
                                      value_left_reg - VALUE_LEFT_W'(1) : '0;
                    if (value_left_next == '0)
                    begin
                        cmp_accum  = accum_next;
                        phase_next = PH_TYPE;
                        if (cmp_accum != {{(ACCUM_W-16){1'b0}}, want})
                        begin
                            v_valid = 1'b1;
                            v_code  = mismatch_code;
                        end
                    end
                end
                PH_ITEM:
                begin
                    unique case (sub_reg)
                        SUB_TYPE:
                        begin
                            if (data_byte == SI_OPTIONS || data_byte == SI_VERSION)
                            begin
                                sub_kind_next = data_byte;
                                sub_next      = SUB_LEN;
                            end
                            else
                            begin
                                v_valid = 1'b1;
                                v_code  = ST_UNKNOWN_SUB;
                            end
                        end
                        SUB_LEN:
                        begin
                            item_left_next = (item_left_reg > 8'd2) ?
                                             item_left_reg - 8'd2 : 8'd0;
                            sub_next       = SUB_VALUE;
                        end
                        default:
                        begin
                            if (sub_kind_reg == SI_OPTIONS && data_byte != cfg.options)
                            begin
                                v_valid = 1'b1;
                                v_code  = ST_OPTIONS;
                            end
                            else if (sub_kind_reg == SI_VERSION &&
                                     data_byte != cfg.version)
                            begin
                                v_valid = 1'b1;
                                v_code  = ST_VERSION;
                            end
                            else
                            begin
                                item_left_next = (item_left_reg > 8'd1) ?
                                                 item_left_reg - 8'd1 : 8'd0;
                                sub_next       = SUB_TYPE;
                                if (item_left_next == 8'd0)
                                begin
                                    phase_next = PH_TYPE;
                                end
                            end
                        end
                    endcase
                end
                default:
                begin
                    phase_next = PH_TYPE;
                end
            endcase
        end

        verdict_next = verdict_reg | v_valid;

        // stream end: report clean or truncated end if no verdict was given, then rearm
        if (last)
        begin
            if (!v_valid && !verdict_reg)
            begin
                v_valid = 1'b1;
                v_code  = (phase_next == PH_TYPE) ? ST_CLEAN_END : ST_TRUNCATED;
                v_udl   = 8'd0;
            end
            phase_next      = PH_TYPE;
            kind_next       = 8'd0;
            item_left_next  = 8'd0;
            sub_next        = SUB_TYPE;
            sub_kind_next   = 8'd0;
            value_left_next = '0;
            accum_next      = '0;
            shift_next      = '0;
            verdict_next    = 1'b0;
        end
    end

    assign res_valid            = fire & v_valid;
    assign res.status           = v_code;
    assign res.user_data_length = v_udl;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TYPE;
            kind_reg       <= 8'd0;
            item_left_reg  <= 8'd0;
            sub_reg        <= SUB_TYPE;
            sub_kind_reg   <= 8'd0;
            value_left_reg <= '0;
            accum_reg      <= '0;
            shift_reg      <= '0;
            verdict_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            item_left_reg  <= item_left_next;
            sub_reg        <= sub_next;
            sub_kind_reg   <= sub_kind_next;
            value_left_reg <= value_left_next;
            accum_reg      <= accum_next;
            shift_reg      <= shift_next;
            verdict_reg    <= verdict_next;
        end
    end

    // once a verdict stands, no further result for the stream
    a_single_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && verdict_reg) |-> !res_valid)
        else $error("result after verdict");

    // length field only carried with user data status
    a_udl_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status != ST_USER_DATA) |-> (res.user_data_length == 8'd0))
        else $error("user data length on other status");

    // in the value phase with no verdict, value bytes are always left
    a_value_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VALUE && !verdict_reg) |-> (value_left_reg != '0))
        else $error("value phase with no bytes left");

endmodule

`default_nettype wire

// ===== rtl/ssp_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ssp_out_fifo
    import ssp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire ssp_result_t  push_data,
    output logic              space,
    output logic              out_valid,
    input  wire logic         out_ready,
    output ssp_result_t       out_data
);

    ssp_result_t  mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         pop;

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("result buffer overflow");

    a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("fill count and pointers disagree");

endmodule

`default_nettype wire

// ===== verif/session_spdu_param_checker_tb.sv =====
`timescale 1ns / 1ps

module session_spdu_param_checker_tb;
    import ssp_pkg::*;

    // index with no register behind it
    localparam logic [2:0] REG_UNMAPPED    = 3'd7;

    localparam int DRAIN_CYCLES = 6;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 80;
    localparam int MAX_SHOWN    = 10;

    typedef enum logic [1:0] {WALK_TYPE, WALK_LEN, WALK_VALUE, WALK_ITEM} walk_phase_t;
    typedef enum logic [1:0] {SUB_TYPE, SUB_LEN, SUB_VALUE} sub_step_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  status;
    logic [7:0]  user_data_length;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // expected register contents
    logic [7:0]  want_options;
    logic [7:0]  want_version;
    logic [15:0] want_session_req;
    logic [15:0] want_calling_sel;
    logic [15:0] want_called_sel;

    // parser state as predicted
    walk_phase_t walk;
    logic [7:0]  kind_seen;
    logic [7:0]  item_left;
    sub_step_t   sub_step;
    logic [7:0]  sub_seen;
    logic [7:0]  value_left;
    logic [63:0] accum;
    logic [2:0]  accum_shift;
    bit          verdict_given;

    ssp_result_t pending_results[$];
    logic [7:0]  spdu_bytes[$];

    int  tx_gap_pct;
    int  rx_stall_pct;
    bit  hold_request;
    int  longest_hold;
    int  bytes_sent;
    int  streams_sent;
    int  results_seen;
    int  cfg_writes;
    int  error_count;

    session_spdu_param_checker uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .last             (last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .user_data_length (user_data_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("%s", msg);
    endfunction

    function automatic bit is_param_type(input logic [7:0] b);
        return b == PT_ACCEPT_ITEM || b == PT_SESSION_REQ || b == PT_CALLING_SEL ||
               b == PT_CALLED_SEL || b == PT_USER_DATA;
    endfunction

    // append one byte to the stream under construction
    function automatic void append_byte(input logic [7:0] b);
        spdu_bytes.insert(spdu_bytes.size(), b);
    endfunction

    // append one predicted word to the queue of results still due
    function automatic void append_result(input ssp_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void rearm_walk();
        walk          = WALK_TYPE;
        kind_seen     = 8'h00;
        item_left     = 8'h00;
        sub_step      = SUB_TYPE;
        sub_seen      = 8'h00;
        value_left    = 8'h00;
        accum         = 64'h0;
        accum_shift   = 3'd0;
        verdict_given = 1'b0;
    endfunction

    function automatic void reset_model();
        want_options     = 8'h00;
        want_version     = 8'h02;
        want_session_req = 16'h0200;
        want_calling_sel = 16'h0100;
        want_called_sel  = 16'h0100;
        rearm_walk();
    endfunction

    // compare the gathered value with its register and go back to type
    function automatic void judge_value(output bit hit, output ssp_status_t verdict);
        logic [15:0] ref_value;
        if (kind_seen == PT_SESSION_REQ)
        begin
            ref_value = want_session_req;
            verdict = ST_REQUIREMENT;
        end
        else if (kind_seen == PT_CALLING_SEL)
        begin
            ref_value = want_calling_sel;
            verdict = ST_CALLING;
        end
        else
        begin
            ref_value = want_called_sel;
            verdict = ST_CALLED;
        end
        walk = WALK_TYPE;
        hit = (accum != {48'h0, ref_value});
    endfunction

    // advance the predicted parser by one byte and queue what it yields
    function automatic void walk_byte(input logic [7:0] b, input logic is_last);
        bit          was_given;
        bit          hit;
        ssp_status_t verdict;
        logic [7:0]  udl;
        ssp_result_t r;
        was_given = verdict_given;
        hit = 1'b0;
        verdict = ST_CLEAN_END;
        udl = 8'h00;
        if (!was_given)
        begin
            case (walk)
                WALK_TYPE:
                begin
                    kind_seen = b;
                    if (is_param_type(b))
                        walk = WALK_LEN;
                    else
                    begin
                        hit = 1'b1;
                        verdict = ST_UNKNOWN_TYPE;
                    end
                end
                WALK_LEN:
                begin
                    if (kind_seen == PT_USER_DATA)
                    begin
                        hit = 1'b1;
                        verdict = ST_USER_DATA;
                        udl = b;
                    end
                    else if (kind_seen == PT_ACCEPT_ITEM)
                    begin
                        item_left = b;
                        sub_step = SUB_TYPE;
                        walk = (b != 8'h00) ? WALK_ITEM : WALK_TYPE;
                    end
                    else if (b > MAX_VALUE_BYTES)
                    begin
                        hit = 1'b1;
                        verdict = ST_TOO_LONG;
                    end
                    else
                    begin
                        accum = 64'h0;
                        accum_shift = 3'd0;
                        value_left = b;
                        if (b == 8'h00)
                            judge_value(hit, verdict);
                        else
                            walk = WALK_VALUE;
                    end
                end
                WALK_VALUE:
                begin
                    // little-endian gather
                    accum = accum | (64'(b) << (8 * accum_shift));
                    accum_shift = accum_shift + 3'd1;
                    value_left = (value_left > 8'd0) ? value_left - 8'd1 : 8'd0;
                    if (value_left == 8'd0)
                        judge_value(hit, verdict);
                end
                default:
                begin
                    // inside a connect accept item
                    if (sub_step == SUB_TYPE)
                    begin
                        if (b == SI_OPTIONS || b == SI_VERSION)
                        begin
                            sub_seen = b;
                            sub_step = SUB_LEN;
                        end
                        else
                        begin
                            hit = 1'b1;
                            verdict = ST_UNKNOWN_SUB;
                        end
                    end
                    else if (sub_step == SUB_LEN)
                    begin
                        item_left = (item_left > 8'd2) ? item_left - 8'd2 : 8'd0;
                        sub_step = SUB_VALUE;
                    end
                    else if (sub_seen == SI_OPTIONS && b != want_options)
                    begin
                        hit = 1'b1;
                        verdict = ST_OPTIONS;
                    end
                    else if (sub_seen == SI_VERSION && b != want_version)
                    begin
                        hit = 1'b1;
                        verdict = ST_VERSION;
                    end
                    else
                    begin
                        item_left = (item_left > 8'd1) ? item_left - 8'd1 : 8'd0;
                        sub_step = SUB_TYPE;
                        if (item_left == 8'd0)
                            walk = WALK_TYPE;
                    end
                end
            endcase
        end
        if (hit)
        begin
            r.status = verdict;
            r.user_data_length = udl;
            append_result(r);
            verdict_given = 1'b1;
        end
        if (is_last)
        begin
            if (!hit && !was_given)
            begin
                r.status = (walk == WALK_TYPE) ? ST_CLEAN_END : ST_TRUNCATED;
                r.user_data_length = 8'h00;
                append_result(r);
            end
            rearm_walk();
        end
    endfunction

    function automatic logic [7:0] unknown_type_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_param_type(b));
        return b;
    endfunction

    // session requirement or selector parameter, mostly matching
    function automatic void add_value_param(input logic [7:0] kind, input logic [15:0] ref_value);
        int len;
        bit faithful;
        faithful = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 19) == 0)
            len = $urandom_range(MAX_VALUE_BYTES + 1, 255);
        else if ($urandom_range(0, 3) == 0)
            len = $urandom_range(0, MAX_VALUE_BYTES);
        else
            len = 2;
        append_byte(kind);
        append_byte(8'(len));
        if (len <= MAX_VALUE_BYTES)
            for (int k = 0; k < len; k++)
                append_byte(faithful ? 8'(ref_value >> (8 * k))
                                     : 8'($urandom_range(0, 255)));
    endfunction

    // connect accept item with up to three sub-items
    function automatic void add_accept_item();
        int subs;
        int item_len;
        bit faithful;
        logic [7:0] sub_kind;
        subs = $urandom_range(0, 3);
        item_len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : 3 * subs;
        append_byte(PT_ACCEPT_ITEM);
        append_byte(8'(item_len));
        for (int s = 0; s < subs; s++)
        begin
            faithful = ($urandom_range(0, 7) != 0);
            sub_kind = $urandom_range(0, 1) ? SI_OPTIONS : SI_VERSION;
            if ($urandom_range(0, 24) == 0)
                sub_kind = 8'($urandom_range(0, 255));
            append_byte(sub_kind);
            append_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'h01);
            if (!faithful)
                append_byte(8'($urandom_range(0, 255)));
            else if (sub_kind == SI_OPTIONS)
                append_byte(want_options);
            else
                append_byte(want_version);
        end
    endfunction

    // one stream: mostly well formed, some cut short, corrupted or pure noise
    function automatic void build_stream();
        int params;
        spdu_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
                append_byte(8'($urandom_range(0, 255)));
            return;
        end
        params = $urandom_range(0, 4);
        repeat (params)
        begin
            case ($urandom_range(0, 3))
                0: add_accept_item();
                1: add_value_param(PT_SESSION_REQ, want_session_req);
                2: add_value_param(PT_CALLING_SEL, want_calling_sel);
                default: add_value_param(PT_CALLED_SEL, want_called_sel);
            endcase
        end
        if (spdu_bytes.size() == 0 || $urandom_range(0, 9) < 7)
        begin
            append_byte(PT_USER_DATA);
            append_byte(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3))
                append_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) == 0)
            spdu_bytes = spdu_bytes[0:$urandom_range(0, spdu_bytes.size() - 1)];
        if ($urandom_range(0, 9) == 0)
            spdu_bytes[$urandom_range(0, spdu_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    // offer one byte and wait for it to be taken
    task automatic send_word(input logic [7:0] b, input logic is_last);
        int gap;
        @(negedge clk);
        if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        walk_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < spdu_bytes.size(); i++)
            send_word(spdu_bytes[i], i == spdu_bytes.size() - 1);
        streams_sent++;
    endtask

    task automatic run_streams(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            build_stream();
            send_stream();
        end
    endtask

    // stop offering, let every expected word arrive, then let the pipe settle
    task automatic drain();
        int waited;
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            flag_error($sformatf("%0d expected results never arrived",
                                 pending_results.size()));
            pending_results.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_OPTIONS:     want_options = val[7:0];
            REG_VERSION:     want_version = val[7:0];
            REG_SESSION_REQ: want_session_req = val;
            REG_CALLING_SEL: want_calling_sel = val;
            REG_CALLED_SEL:  want_called_sel = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input logic [15:0] opt, input logic [15:0] ver,
                           input logic [15:0] req, input logic [15:0] calling,
                           input logic [15:0] called);
        write_reg(REG_OPTIONS, opt);
        write_reg(REG_VERSION, ver);
        write_reg(REG_SESSION_REQ, req);
        write_reg(REG_CALLING_SEL, calling);
        write_reg(REG_CALLED_SEL, called);
    endtask

    // hand-built streams against the reset register values
    task automatic test_directed();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        // accept item whose count runs out early, requirement, user data of max length
        spdu_bytes = '{PT_ACCEPT_ITEM, 8'h01, SI_OPTIONS, 8'h05, 8'h00,
                       PT_SESSION_REQ, 8'h02, 8'h00, 8'h02, PT_USER_DATA, 8'hFF};
        send_stream();
        // unknown type, then bytes ignored until last
        spdu_bytes = '{8'h07, 8'h00, 8'hFF};
        send_stream();
        // zero-length called selector
        spdu_bytes = '{PT_CALLED_SEL, 8'h00};
        send_stream();
        // value too long
        spdu_bytes = '{PT_CALLING_SEL, 8'h09, 8'h00};
        send_stream();
        // empty accept item then clean end
        spdu_bytes = '{PT_ACCEPT_ITEM, 8'h00};
        send_stream();
        // stream ends on the user data type byte
        spdu_bytes = '{PT_USER_DATA};
        send_stream();
        // wrong version
        spdu_bytes = '{PT_ACCEPT_ITEM, 8'h03, SI_VERSION, 8'h01, 8'h03};
        send_stream();
        // unknown sub-item
        spdu_bytes = '{PT_ACCEPT_ITEM, 8'h03, 8'hEE};
        send_stream();
        drain();
    endtask

    // all-zero and all-ones registers, plus a write to an unmapped index
    task automatic test_config_extremes();
        tx_gap_pct = 6;
        rx_stall_pct = 6;
        set_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_streams(200);
        drain();
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
        run_streams(200);
        drain();
    endtask

    // random register settings, then the reset values, under different idle mixes
    task automatic test_random_settings();
        for (int p = 0; p < 4; p++)
        begin
            tx_gap_pct   = (p == 0 || p == 2) ? 8 : 0;
            rx_stall_pct = (p == 0 || p == 1) ? 8 : 0;
            if (p == 3)
                set_all(16'h0000, 16'h0002, 16'h0200, 16'h0100, 16'h0100);
            else
                set_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
            run_streams(230);
            drain();
        end
    endtask

    // long receiver hold while every byte yields a word, so input stalls; then random streams
    task automatic test_output_hold();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        hold_request = 1'b1;
        repeat (60)
        begin
            send_word(unknown_type_byte(), 1'b1);
            streams_sent++;
        end
        drain();
        tx_gap_pct = 10;
        rx_stall_pct = 10;
        run_streams(100);
        drain();
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        set_all(16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
        run_streams(450);
        drain();
    endtask

    // receiver ready: random stalls, or one long hold on request
    initial
    begin
        int held;
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                held = 1;
                while (held < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    held++;
                end
                if (held > longest_hold)
                    longest_hold = held;
                hold_request = 1'b0;
            end
            else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct)
            begin
                stall = $urandom_range(1, 17);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // compare each taken word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        ssp_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                flag_error($sformatf("unexpected result: status %0d length %0d",
                                     status, user_data_length));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || user_data_length !== want.user_data_length)
                    flag_error($sformatf(
                        "result %0d: status %0d length %0d, wanted status %0d length %0d",
                        results_seen, status, user_data_length,
                        want.status, want.user_data_length));
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        last         = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_OPTIONS;
        cfg_data     = 16'h0000;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_request = 1'b0;
        longest_hold = 0;
        bytes_sent   = 0;
        streams_sent = 0;
        results_seen = 0;
        cfg_writes   = 0;
        error_count  = 0;
        reset_model();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_config_extremes();
        test_random_settings();
        test_output_hold();
        test_full_rate();

        $display("%0d bytes in %0d streams sent, %0d results checked, %0d register writes",
                 bytes_sent, streams_sent, results_seen, cfg_writes);
        $display("longest output hold %0d cycles, %0d problems found",
                 longest_hold, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
